### rtl/core/plldivs_pkg.sv
// Package for the PLL divider search: constants, defaults, register map and sequencer states.
package plldivs_pkg;

    // Default divider ranges, handed to the top level as parameter defaults.
    localparam int FBDIV_MIN_DEF   = 16;
    localparam int FBDIV_MAX_DEF   = 320;
    localparam int POSTDIV_MAX_DEF = 7;

    // Field widths fixed by the interface.
    localparam int REF_W  = 16;
    localparam int KHZ_W  = 24;
    localparam int FB_W   = 9;
    localparam int PD_W   = 3;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // Error bound: a candidate is kept only if its error lies below this.
    localparam int ERR_LIMIT = 100000;
    localparam int ERR_W     = 17;

    // Cycles between the last candidate issued and the final best value.
    localparam int DRAIN_LEN = 4;
    localparam int DRAIN_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_REF_KHZ  = 2'd0;
    localparam logic [1:0] REG_VCO_MIN  = 2'd1;
    localparam logic [1:0] REG_VCO_MAX  = 2'd2;
    localparam logic [1:0] REG_LOW_VCO  = 2'd3;

    // Register reset values.
    localparam logic [REF_W - 1:0] RST_REF_KHZ = 16'd12000;
    localparam logic [KHZ_W - 1:0] RST_VCO_MIN = 24'd400000;
    localparam logic [KHZ_W - 1:0] RST_VCO_MAX = 24'd1600000;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } seq_state_t;

endpackage

### rtl/core/pll_divider_search_core.sv
// PLL feedback and post-divider search: sequencer, pipelined divide unit and best-candidate store.
//
// A transfer is accepted when start is high while busy is low; busy then stays high until the
// answer is ready. The block walks every feedback divider (FBDIV_MAX - FBDIV_MIN + 1 of them)
// and for each one every post-divider pair with POSTDIV_MAX >= pd1 >= pd2 >= 1, issuing one
// candidate per cycle into a single shared divide unit (reciprocal table multiply followed
// by a one-step correction) and a compare stage. The scan therefore covers
// Nfb * P * (P + 1) / 2 candidates, with P = POSTDIV_MAX, then drains the pipeline and finishes:
// 305 * 28 = 8540 candidates with the default ranges. The result appears on the
// output ports for exactly one cycle, marked by done, and the receiver cannot hold it off; the
// fields keep their values until the next request is taken. When no candidate lies in the VCO
// window with an error below 100000 kHz, every field, exact included, reads zero.
module pll_divider_search_core #(
    parameter int FBDIV_MIN   = plldivs_pkg::FBDIV_MIN_DEF,
    parameter int FBDIV_MAX   = plldivs_pkg::FBDIV_MAX_DEF,
    parameter int POSTDIV_MAX = plldivs_pkg::POSTDIV_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [plldivs_pkg::KHZ_W - 1:0]     req_khz,
    // Result channel
    output logic                                done,
    output logic [plldivs_pkg::KHZ_W - 1:0]     out_khz,
    output logic [plldivs_pkg::KHZ_W - 1:0]     out_vco_khz,
    output logic [plldivs_pkg::FB_W - 1:0]      feedback_div,
    output logic [plldivs_pkg::PD_W - 1:0]      post_div1,
    output logic [plldivs_pkg::PD_W - 1:0]      post_div2,
    output logic                                exact,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [plldivs_pkg::ADDR_W - 1:0]    paddr,
    input  logic [plldivs_pkg::DATA_W - 1:0]    pwdata,
    output logic [plldivs_pkg::DATA_W - 1:0]    prdata,
    output logic                                pready
);

    // Derived widths.
    localparam int FBW   = $clog2(FBDIV_MAX + 1);
    localparam int PW    = $clog2(POSTDIV_MAX + 1);
    localparam int DMAX  = POSTDIV_MAX * POSTDIV_MAX;
    localparam int DW    = $clog2(DMAX + 1);
    localparam int VW    = plldivs_pkg::REF_W + FBW;
    localparam int SH    = VW;
    localparam int RW    = VW + 1;
    localparam int PRW   = VW + RW;
    localparam int CW    = (VW > plldivs_pkg::KHZ_W) ? VW : plldivs_pkg::KHZ_W;
    localparam int EW    = plldivs_pkg::ERR_W;

    localparam logic             EMPTY_RANGE = (FBDIV_MIN > FBDIV_MAX);
    localparam logic [FBW - 1:0] FB_LO       = FBW'(FBDIV_MIN);
    localparam logic [FBW - 1:0] FB_HI       = FBW'(FBDIV_MAX);
    localparam logic [PW - 1:0]  PD_TOP      = PW'(POSTDIV_MAX);
    localparam logic [EW - 1:0]  ERR_INIT    = EW'(plldivs_pkg::ERR_LIMIT);

    // Configuration registers.
    logic [plldivs_pkg::REF_W - 1:0] ref_reg;
    logic [plldivs_pkg::KHZ_W - 1:0] vmin_reg;
    logic [plldivs_pkg::KHZ_W - 1:0] vmax_reg;
    logic                            low_vco_reg;
    logic                            cfg_wr;

    // Sequencer.
    plldivs_pkg::seq_state_t         state_reg, state_next;
    logic [FBW - 1:0]                fb_reg, fb_next;
    logic [PW - 1:0]                 pd1_reg, pd1_next;
    logic [PW - 1:0]                 pd2_reg, pd2_next;
    logic [plldivs_pkg::DRAIN_W - 1:0] drain_reg, drain_next;
    logic [plldivs_pkg::KHZ_W - 1:0] req_reg;
    logic                            done_reg;
    logic                            accept;
    logic [FBW - 1:0]                fb_first, fb_last;

    // Pipeline stage 1: VCO and divisor products.
    logic              s1_vld_reg;
    logic [VW - 1:0]   s1_vco_reg, s1_vco_next;
    logic [DW - 1:0]   s1_d_reg, s1_d_next;
    logic [FBW - 1:0]  s1_fb_reg;
    logic [PW - 1:0]   s1_pd1_reg, s1_pd2_reg;

    // Pipeline stage 2: reciprocal product.
    logic              s2_vld_reg, s2_vld_next;
    logic [PRW - 1:0]  s2_prod_reg, s2_prod_next;
    logic [VW - 1:0]   s2_vco_reg;
    logic [DW - 1:0]   s2_d_reg;
    logic [FBW - 1:0]  s2_fb_reg;
    logic [PW - 1:0]   s2_pd1_reg, s2_pd2_reg;

    // Pipeline stage 3: corrected quotient.
    logic              s3_vld_reg;
    logic [VW - 1:0]   s3_q_reg, s3_q_next;
    logic              s3_div_reg, s3_div_next;
    logic [VW - 1:0]   s3_vco_reg;
    logic [FBW - 1:0]  s3_fb_reg;
    logic [PW - 1:0]   s3_pd1_reg, s3_pd2_reg;

    // Pipeline stage 4: absolute error.
    logic              s4_vld_reg;
    logic [CW - 1:0]   s4_err_reg, s4_err_next;
    logic              s4_div_reg;
    logic [VW - 1:0]   s4_q_reg;
    logic [VW - 1:0]   s4_vco_reg;
    logic [FBW - 1:0]  s4_fb_reg;
    logic [PW - 1:0]   s4_pd1_reg, s4_pd2_reg;

    // Best candidate so far.
    logic [EW - 1:0]   best_err_reg;
    logic [VW - 1:0]   best_khz_reg;
    logic [VW - 1:0]   best_vco_reg;
    logic [FBW - 1:0]  best_fb_reg;
    logic [PW - 1:0]   best_pd1_reg, best_pd2_reg;
    logic              best_exact_reg;
    logic              best_upd;

    // Reciprocal table, floor(2^SH / d), built at elaboration.
    logic [RW - 1:0]   rcp_tab [0:DMAX];

    // Intermediate values of the divide unit.
    logic [VW - 1:0]   q0, qd, rem0;
    logic              corr;
    logic [CW - 1:0]   qx, rx;
    logic              in_win;

    genvar gd;
    generate
        for (gd = 0; gd <= DMAX; gd++)
        begin : g_rcp
            localparam logic [RW - 1:0] RCP = RW'((64'd1 << SH) / ((gd == 0) ? 1 : gd));
            assign rcp_tab[gd] = RCP;
        end
    endgenerate

    // Configuration port: writes complete in the access phase, reads are combinational.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg     <= plldivs_pkg::RST_REF_KHZ;
            vmin_reg    <= plldivs_pkg::RST_VCO_MIN;
            vmax_reg    <= plldivs_pkg::RST_VCO_MAX;
            low_vco_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                plldivs_pkg::REG_REF_KHZ: ref_reg     <= pwdata[plldivs_pkg::REF_W - 1:0];
                plldivs_pkg::REG_VCO_MIN: vmin_reg    <= pwdata[plldivs_pkg::KHZ_W - 1:0];
                plldivs_pkg::REG_VCO_MAX: vmax_reg    <= pwdata[plldivs_pkg::KHZ_W - 1:0];
                plldivs_pkg::REG_LOW_VCO: low_vco_reg <= pwdata[0];
                default:                  low_vco_reg <= low_vco_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            plldivs_pkg::REG_REF_KHZ: prdata = 32'(ref_reg);
            plldivs_pkg::REG_VCO_MIN: prdata = 32'(vmin_reg);
            plldivs_pkg::REG_VCO_MAX: prdata = 32'(vmax_reg);
            plldivs_pkg::REG_LOW_VCO: prdata = 32'(low_vco_reg);
            default:                  prdata = '0;
        endcase
    end

    // Sequencer: walks feedback divider, then pd1 downward, then pd2 downward from pd1.
    assign busy     = (state_reg != plldivs_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign fb_first = low_vco_reg ? FB_LO : FB_HI;
    assign fb_last  = low_vco_reg ? FB_HI : FB_LO;

    always_comb
    begin
        state_next = state_reg;
        fb_next    = fb_reg;
        pd1_next   = pd1_reg;
        pd2_next   = pd2_reg;
        drain_next = drain_reg;
        case (state_reg)
            plldivs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    fb_next    = fb_first;
                    pd1_next   = PD_TOP;
                    pd2_next   = PD_TOP;
                    drain_next = '0;
                    state_next = EMPTY_RANGE ? plldivs_pkg::S_DRAIN : plldivs_pkg::S_SCAN;
                end
            end
            plldivs_pkg::S_SCAN:
            begin
                if (pd2_reg != PW'(1))
                begin
                    pd2_next = pd2_reg - PW'(1);
                end
                else if (pd1_reg != PW'(1))
                begin
                    pd1_next = pd1_reg - PW'(1);
                    pd2_next = pd1_reg - PW'(1);
                end
                else if (fb_reg == fb_last)
                begin
                    state_next = plldivs_pkg::S_DRAIN;
                end
                else
                begin
                    fb_next  = low_vco_reg ? fb_reg + FBW'(1) : fb_reg - FBW'(1);
                    pd1_next = PD_TOP;
                    pd2_next = PD_TOP;
                end
            end
            plldivs_pkg::S_DRAIN:
            begin
                drain_next = drain_reg + plldivs_pkg::DRAIN_W'(1);
                if (drain_reg == plldivs_pkg::DRAIN_W'(plldivs_pkg::DRAIN_LEN - 1))
                begin
                    state_next = plldivs_pkg::S_FINISH;
                end
            end
            plldivs_pkg::S_FINISH:
            begin
                state_next = plldivs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = plldivs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plldivs_pkg::S_IDLE;
            fb_reg    <= '0;
            pd1_reg   <= '0;
            pd2_reg   <= '0;
            drain_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fb_reg    <= fb_next;
            pd1_reg   <= pd1_next;
            pd2_reg   <= pd2_next;
            drain_reg <= drain_next;
            done_reg  <= (state_reg == plldivs_pkg::S_FINISH);
        end
    end

    // Request is held for the whole scan.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_khz;
        end
    end

    // Datapath of the shared divide unit.
    always_comb
    begin
        s1_vco_next  = VW'(fb_reg) * VW'(ref_reg);
        s1_d_next    = DW'(pd1_reg) * DW'(pd2_reg);

        in_win       = (CW'(s1_vco_reg) >= CW'(vmin_reg)) && (CW'(s1_vco_reg) <= CW'(vmax_reg));
        s2_vld_next  = s1_vld_reg && in_win;
        s2_prod_next = PRW'(s1_vco_reg) * PRW'(rcp_tab[s1_d_reg]);

        // The reciprocal estimate is at most one below the true quotient.
        q0           = VW'(s2_prod_reg >> SH);
        qd           = VW'(q0 * VW'(s2_d_reg));
        rem0         = s2_vco_reg - qd;
        corr         = (rem0 >= VW'(s2_d_reg));
        s3_q_next    = q0 + VW'(corr);
        s3_div_next  = corr ? (rem0 == VW'(s2_d_reg)) : (rem0 == '0);

        qx           = CW'(s3_q_reg);
        rx           = CW'(req_reg);
        s4_err_next  = (qx >= rx) ? (qx - rx) : (rx - qx);

        best_upd     = s4_vld_reg && (s4_err_reg < CW'(best_err_reg));
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= (state_reg == plldivs_pkg::S_SCAN);
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        s1_vco_reg  <= s1_vco_next;
        s1_d_reg    <= s1_d_next;
        s1_fb_reg   <= fb_reg;
        s1_pd1_reg  <= pd1_reg;
        s1_pd2_reg  <= pd2_reg;

        s2_prod_reg <= s2_prod_next;
        s2_vco_reg  <= s1_vco_reg;
        s2_d_reg    <= s1_d_reg;
        s2_fb_reg   <= s1_fb_reg;
        s2_pd1_reg  <= s1_pd1_reg;
        s2_pd2_reg  <= s1_pd2_reg;

        s3_q_reg    <= s3_q_next;
        s3_div_reg  <= s3_div_next;
        s3_vco_reg  <= s2_vco_reg;
        s3_fb_reg   <= s2_fb_reg;
        s3_pd1_reg  <= s2_pd1_reg;
        s3_pd2_reg  <= s2_pd2_reg;

        s4_err_reg  <= s4_err_next;
        s4_div_reg  <= s3_div_reg;
        s4_q_reg    <= s3_q_reg;
        s4_vco_reg  <= s3_vco_reg;
        s4_fb_reg   <= s3_fb_reg;
        s4_pd1_reg  <= s3_pd1_reg;
        s4_pd2_reg  <= s3_pd2_reg;
    end

    // Best candidate: cleared when a request is taken, replaced only on a strictly smaller error.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            best_err_reg   <= ERR_INIT;
            best_khz_reg   <= '0;
            best_vco_reg   <= '0;
            best_fb_reg    <= '0;
            best_pd1_reg   <= '0;
            best_pd2_reg   <= '0;
            best_exact_reg <= 1'b0;
        end
        else if (best_upd)
        begin
            best_err_reg   <= EW'(s4_err_reg);
            best_khz_reg   <= s4_q_reg;
            best_vco_reg   <= s4_vco_reg;
            best_fb_reg    <= s4_fb_reg;
            best_pd1_reg   <= s4_pd1_reg;
            best_pd2_reg   <= s4_pd2_reg;
            best_exact_reg <= (s4_err_reg == '0) && s4_div_reg;
        end
    end

    // Result ports.
    assign done         = done_reg;
    assign out_khz      = plldivs_pkg::KHZ_W'(best_khz_reg);
    assign out_vco_khz  = plldivs_pkg::KHZ_W'(best_vco_reg);
    assign feedback_div = plldivs_pkg::FB_W'(best_fb_reg);
    assign post_div1    = plldivs_pkg::PD_W'(best_pd1_reg);
    assign post_div2    = plldivs_pkg::PD_W'(best_pd2_reg);
    assign exact        = best_exact_reg;

    // The result strobe follows the finishing cycle and nothing else.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == plldivs_pkg::S_FINISH))
        else $error("done raised without a finishing cycle");

    // Candidates enter the divide unit only while scanning.
    a_issue_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> $past(state_reg == plldivs_pkg::S_SCAN))
        else $error("candidate issued outside the scan");

    // The pipeline is empty whenever the block is free to take a request.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(s1_vld_reg || s2_vld_reg || s3_vld_reg || s4_vld_reg))
        else $error("pipeline still holds candidates while idle");

    // Within one search the best error never grows.
    a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy)) |-> (best_err_reg <= $past(best_err_reg)))
        else $error("best error increased during a search");

    // Post-divider counters stay ordered and nonzero during the scan.
    a_pd_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plldivs_pkg::S_SCAN) |-> (pd2_reg <= pd1_reg) && (pd2_reg != '0))
        else $error("post-divider counters out of order");

endmodule

### tb/pll_divider_search_core_test.sv
// Self-checking testbench for the PLL divider search core: directed table, random phases, APB set-up.
module pll_divider_search_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Package constants used throughout the bench.
    localparam int         FBDIV_MIN_DEF   = plldivs_pkg::FBDIV_MIN_DEF;
    localparam int         FBDIV_MAX_DEF   = plldivs_pkg::FBDIV_MAX_DEF;
    localparam int         POSTDIV_MAX_DEF = plldivs_pkg::POSTDIV_MAX_DEF;
    localparam int         REF_W           = plldivs_pkg::REF_W;
    localparam int         KHZ_W           = plldivs_pkg::KHZ_W;
    localparam int         FB_W            = plldivs_pkg::FB_W;
    localparam int         PD_W            = plldivs_pkg::PD_W;
    localparam int         DATA_W          = plldivs_pkg::DATA_W;
    localparam int         ADDR_W          = plldivs_pkg::ADDR_W;
    localparam int         ERR_LIMIT       = plldivs_pkg::ERR_LIMIT;
    localparam int         DRAIN_LEN       = plldivs_pkg::DRAIN_LEN;
    localparam logic [1:0] REG_REF_KHZ     = plldivs_pkg::REG_REF_KHZ;
    localparam logic [1:0] REG_VCO_MIN     = plldivs_pkg::REG_VCO_MIN;
    localparam logic [1:0] REG_VCO_MAX     = plldivs_pkg::REG_VCO_MAX;
    localparam logic [1:0] REG_LOW_VCO     = plldivs_pkg::REG_LOW_VCO;

    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    localparam int          FB_SPAN     = FBDIV_MAX_DEF - FBDIV_MIN_DEF + 1;
    localparam int          PLAN_LEN    = 21;
    localparam int          PHASES      = 5;
    localparam int          PHASE_ITEMS = 20;

    typedef longint unsigned u64_t;

    // One search answer, laid out as the result ports are.
    typedef struct packed {
        logic [KHZ_W - 1:0] khz;
        logic [KHZ_W - 1:0] vco;
        logic [FB_W - 1:0]  fb;
        logic [PD_W - 1:0]  pd1;
        logic [PD_W - 1:0]  pd2;
        logic               exact;
    } pll_setting_t;

    localparam pll_setting_t NOTHING_FOUND = '0;

    // One row of the directed table: register settings, request and, where obvious, the answer.
    typedef struct {
        logic [REF_W - 1:0] ref_khz;
        logic [KHZ_W - 1:0] vco_min;
        logic [KHZ_W - 1:0] vco_max;
        logic               low_vco;
        logic [KHZ_W - 1:0] req;
        logic               known;
        pll_setting_t       want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    logic [KHZ_W - 1:0]    req_khz = '0;
    logic                  done;
    logic [KHZ_W - 1:0]    out_khz;
    logic [KHZ_W - 1:0]    out_vco_khz;
    logic [FB_W - 1:0]     feedback_div;
    logic [PD_W - 1:0]     post_div1;
    logic [PD_W - 1:0]     post_div2;
    logic                  exact;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W - 1:0]   paddr   = '0;
    logic [DATA_W - 1:0]   pwdata  = '0;
    logic [DATA_W - 1:0]   prdata;
    logic                  pready;

    // Shadow copy of the registers, starting from their reset values.
    logic [REF_W - 1:0]    sh_ref_khz = 16'd12000;
    logic [KHZ_W - 1:0]    sh_vco_min = 24'd400000;
    logic [KHZ_W - 1:0]    sh_vco_max = 24'd1600000;
    logic                  sh_low_vco = 1'b0;

    pll_setting_t          pending_settings [$];
    plan_row_t             plan [PLAN_LEN];
    int                    errors      = 0;
    int                    burst_left  = 0;
    bit                    start_high  = 1'b0;
    int unsigned           cycle_count = 0;

    pll_divider_search_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_khz      (req_khz),
        .done         (done),
        .out_khz      (out_khz),
        .out_vco_khz  (out_vco_khz),
        .feedback_div (feedback_div),
        .post_div1    (post_div1),
        .post_div2    (post_div2),
        .exact        (exact),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Exhaustive search over the current shadow settings, in the block's own scan order.
    function automatic pll_setting_t search_best_setting(input logic [KHZ_W - 1:0] req);
        u64_t         best_err, fb, vco, khz, err, p1, p2;
        u64_t         b_khz, b_vco, b_fb, b_p1, b_p2;
        pll_setting_t best;
        bit           found;
        best     = NOTHING_FOUND;
        found    = 1'b0;
        best_err = ERR_LIMIT;
        b_khz    = 0;
        b_vco    = 0;
        b_fb     = 0;
        b_p1     = 0;
        b_p2     = 0;
        for (u64_t i = 0; i < FB_SPAN; i++)
        begin
            fb  = sh_low_vco ? FBDIV_MIN_DEF + i : FBDIV_MAX_DEF - i;
            vco = fb * sh_ref_khz;
            if (vco >= sh_vco_min && vco <= sh_vco_max)
            begin
                for (p1 = POSTDIV_MAX_DEF; p1 >= 1; p1--)
                begin
                    for (p2 = p1; p2 >= 1; p2--)
                    begin
                        khz = vco / (p1 * p2);
                        err = (khz >= req) ? khz - req : req - khz;
                        // Strictly smaller only, so the earliest candidate keeps a tie.
                        if (err < best_err)
                        begin
                            best_err = err;
                            found    = 1'b1;
                            b_khz    = khz;
                            b_vco    = vco;
                            b_fb     = fb;
                            b_p1     = p1;
                            b_p2     = p2;
                        end
                    end
                end
            end
        end
        best.khz   = b_khz[KHZ_W - 1:0];
        best.vco   = b_vco[KHZ_W - 1:0];
        best.fb    = b_fb[FB_W - 1:0];
        best.pd1   = b_p1[PD_W - 1:0];
        best.pd2   = b_p2[PD_W - 1:0];
        best.exact = found && b_khz == req && b_vco == b_khz * b_p1 * b_p2;
        return best;
    endfunction

    // Value a register read should return, zero-extended to the data width.
    function automatic logic [DATA_W - 1:0] register_value(input logic [1:0] idx);
        logic [DATA_W - 1:0] value;
        case (idx)
            REG_REF_KHZ: value = DATA_W'(sh_ref_khz);
            REG_VCO_MIN: value = DATA_W'(sh_vco_min);
            REG_VCO_MAX: value = DATA_W'(sh_vco_max);
            default:     value = DATA_W'(sh_low_vco);
        endcase
        return value;
    endfunction

    // Random request: mostly near reachable frequencies, some exact hits, some anywhere.
    function automatic logic [KHZ_W - 1:0] pick_request();
        u64_t               fb, p1, p2, hi;
        logic [KHZ_W - 1:0] req;
        case ($urandom_range(0, 9))
            0, 1:
                req = KHZ_W'($urandom);
            2, 3, 4:
            begin
                hi = sh_vco_max + ERR_LIMIT;
                if (hi > 24'hFFFFFF)
                    hi = 24'hFFFFFF;
                req = KHZ_W'($urandom_range(0, int'(hi)));
            end
            default:
            begin
                fb  = $urandom_range(FBDIV_MIN_DEF, FBDIV_MAX_DEF);
                p1  = $urandom_range(1, POSTDIV_MAX_DEF);
                p2  = $urandom_range(1, int'(p1));
                req = KHZ_W'((fb * sh_ref_khz) / (p1 * p2) + $urandom_range(0, 2));
            end
        endcase
        return req;
    endfunction

    task automatic lower_start();
        if (start_high)
        begin
            start      <= 1'b0;
            start_high  = 1'b0;
        end
    endtask

    // Register write over APB, with random data above the register's width.
    task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W - 1:0] value);
        logic [DATA_W - 1:0] mask;
        case (idx)
            REG_REF_KHZ:              mask = 32'h0000_FFFF;
            REG_VCO_MIN, REG_VCO_MAX: mask = 32'h00FF_FFFF;
            default:                  mask = 32'h0000_0001;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~mask) | (value & mask);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REF_KHZ: sh_ref_khz = value[REF_W - 1:0];
            REG_VCO_MIN: sh_vco_min = value[KHZ_W - 1:0];
            REG_VCO_MAX: sh_vco_max = value[KHZ_W - 1:0];
            default:     sh_low_vco = value[0];
        endcase
        @(posedge clk);
    endtask

    // Register read over APB, compared with the shadow copy.
    task automatic check_register(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== register_value(idx))
        begin
            errors++;
            $display("%0t ns: register %0d read: expected %0d, actual %0d",
                     $time, idx, register_value(idx), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Changes the registers that differ; the block must be idle with nothing outstanding.
    task automatic apply_settings(input logic [REF_W - 1:0] ref_khz,
                                  input logic [KHZ_W - 1:0] vco_min,
                                  input logic [KHZ_W - 1:0] vco_max,
                                  input logic               low_vco);
        if (ref_khz !== sh_ref_khz || vco_min !== sh_vco_min ||
            vco_max !== sh_vco_max || low_vco !== sh_low_vco)
        begin
            lower_start();
            while (pending_settings.size() != 0 || busy !== 1'b0)
                @(posedge clk);
            if (ref_khz !== sh_ref_khz)
                cfg_write(REG_REF_KHZ, DATA_W'(ref_khz));
            if (vco_min !== sh_vco_min)
                cfg_write(REG_VCO_MIN, DATA_W'(vco_min));
            if (vco_max !== sh_vco_max)
                cfg_write(REG_VCO_MAX, DATA_W'(vco_max));
            if (low_vco !== sh_low_vco)
                cfg_write(REG_LOW_VCO, DATA_W'(low_vco));
            check_register(REG_REF_KHZ);
            check_register(REG_VCO_MIN);
            check_register(REG_VCO_MAX);
            check_register(REG_LOW_VCO);
        end
    endtask

    // Bursts of back-to-back requests; a gap before each burst, short or landing mid-search.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 6);
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(10, 9000);
            lower_start();
            repeat (gap) @(posedge clk);
        end
        burst_left--;
    endtask

    // Offers one request and, once the transfer is taken, records what it should produce.
    task automatic issue_request(input logic [KHZ_W - 1:0] req, input logic known,
                                 input pll_setting_t want);
        req_khz <= req;
        if (!start_high)
        begin
            start      <= 1'b1;
            start_high  = 1'b1;
        end
        do @(posedge clk); while (busy !== 1'b0);
        pending_settings.push_back(known ? want : search_best_setting(req));
    endtask

    task automatic check_field(input string name, input logic [KHZ_W - 1:0] want,
                               input logic [KHZ_W - 1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker: every strobed result against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        pll_setting_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (pending_settings.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result: expected none, actual out_khz %0d",
                         $time, out_khz);
            end
            else
            begin
                want = pending_settings.pop_front();
                check_field("out_khz", want.khz, out_khz);
                check_field("out_vco_khz", want.vco, out_vco_khz);
                check_field("feedback_div", KHZ_W'(want.fb), KHZ_W'(feedback_div));
                check_field("post_div1", KHZ_W'(want.pd1), KHZ_W'(post_div1));
                check_field("post_div2", KHZ_W'(want.pd2), KHZ_W'(post_div2));
                check_field("exact", KHZ_W'(want.exact), KHZ_W'(exact));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [REF_W - 1:0] ref_pick;
        logic [KHZ_W - 1:0] lo_pick;
        u64_t               hi_pick;

        // Directed table: defaults, exact hit, out of reach, empty and single-point windows,
        // zero reference on both scan directions, error bound edge, widest reference.
        plan = '{
            '{12000, 400000, 1600000, 1'b0, 1596000, 1'b1,
              '{24'd1596000, 24'd1596000, 9'd133, 3'd1, 3'd1, 1'b1}},
            '{12000, 400000, 1600000, 1'b0, 24'hFFFFFF, 1'b1, NOTHING_FOUND},
            '{12000, 400000, 1600000, 1'b0, 0, 1'b0, NOTHING_FOUND},
            '{12000, 400000, 1600000, 1'b0, 125000, 1'b0, NOTHING_FOUND},
            '{12000, 400000, 1600000, 1'b0, 24'h555555, 1'b0, NOTHING_FOUND},
            '{12000, 400000, 1600000, 1'b0, 24'hAAAAAA, 1'b0, NOTHING_FOUND},
            '{12000, 400000, 1600000, 1'b1, 1596000, 1'b1,
              '{24'd1596000, 24'd1596000, 9'd133, 3'd1, 3'd1, 1'b1}},
            '{12000, 400000, 1600000, 1'b1, 48000, 1'b0, NOTHING_FOUND},
            '{12000, 1000000, 999999, 1'b0, 100000, 1'b1, NOTHING_FOUND},
            '{0, 0, 24'hFFFFFF, 1'b0, 0, 1'b1,
              '{24'd0, 24'd0, 9'd320, 3'd7, 3'd7, 1'b1}},
            '{0, 0, 24'hFFFFFF, 1'b1, 0, 1'b1,
              '{24'd0, 24'd0, 9'd16, 3'd7, 3'd7, 1'b1}},
            '{0, 0, 24'hFFFFFF, 1'b1, 99999, 1'b1,
              '{24'd0, 24'd0, 9'd16, 3'd7, 3'd7, 1'b0}},
            '{0, 0, 24'hFFFFFF, 1'b1, 100000, 1'b1, NOTHING_FOUND},
            '{0, 1, 24'hFFFFFF, 1'b1, 0, 1'b1, NOTHING_FOUND},
            '{16'hFFFF, 0, 24'hFFFFFF, 1'b0, 24'hFFFFFF, 1'b1,
              '{24'd16776960, 24'd16776960, 9'd256, 3'd1, 3'd1, 1'b0}},
            '{16'hFFFF, 0, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1,
              '{24'd16776960, 24'd16776960, 9'd256, 3'd1, 3'd1, 1'b0}},
            '{16'hFFFF, 0, 24'hFFFFFF, 1'b1, 0, 1'b0, NOTHING_FOUND},
            '{1000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1, 1'b1, NOTHING_FOUND},
            '{50000, 0, 0, 1'b0, 0, 1'b1, NOTHING_FOUND},
            '{50000, 0, 24'hFFFFFF, 1'b0, 1000000, 1'b0, NOTHING_FOUND},
            '{1000, 0, 24'hFFFFFF, 1'b0, 7, 1'b0, NOTHING_FOUND}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers must come out of reset at their documented values.
        check_register(REG_REF_KHZ);
        check_register(REG_VCO_MIN);
        check_register(REG_VCO_MAX);
        check_register(REG_LOW_VCO);

        for (int k = 0; k < PLAN_LEN; k++)
        begin
            apply_settings(plan[k].ref_khz, plan[k].vco_min, plan[k].vco_max, plan[k].low_vco);
            pace_sender();
            issue_request(plan[k].req, plan[k].known, plan[k].want);
        end

        // Random phases: each one waits for all outstanding results, then retunes the block.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       ref_pick = '0;
                1:       ref_pick = '1;
                2:       ref_pick = REF_W'($urandom);
                default: ref_pick = REF_W'($urandom_range(1000, 50000));
            endcase
            case ($urandom_range(0, 7))
                0:
                begin
                    lo_pick = '0;
                    hi_pick = 24'hFFFFFF;
                end
                1:
                begin
                    lo_pick = KHZ_W'($urandom);
                    hi_pick = KHZ_W'($urandom);
                end
                default:
                begin
                    lo_pick = KHZ_W'($urandom_range(100000, 800000));
                    hi_pick = lo_pick + $urandom_range(200000, 2000000);
                    if (hi_pick > 24'hFFFFFF)
                        hi_pick = 24'hFFFFFF;
                end
            endcase
            apply_settings(ref_pick, lo_pick, hi_pick[KHZ_W - 1:0], 1'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pace_sender();
                issue_request(pick_request(), 1'b0, NOTHING_FOUND);
            end
        end

        // Drain: every result in, then a few more cycles to catch anything extra.
        lower_start();
        while (pending_settings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_LEN + 16) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/core/plldivs_pkg.sv
rtl/core/pll_divider_search_core.sv
tb/pll_divider_search_core_test.sv
